>>> rtl/core/sdcis_pkg.sv
// shared types and constants for the sd card init/read sequencer
// no dependencies; imported by sdcis_step and sd_card_init_read_sequencer
`timescale 1ns / 1ps

package sdcis_pkg;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_CMD0   = 4'd1,
        PH_CMD8   = 4'd2,
        PH_CMD55  = 4'd3,
        PH_ACMD41 = 4'd4,
        PH_CMD2   = 4'd5,
        PH_CMD3   = 4'd6,
        PH_CMD7   = 4'd7,
        PH_CHK13  = 4'd8,
        PH_CHK7   = 4'd9,
        PH_CMD17  = 4'd10,
        PH_DATA   = 4'd11,
        PH_RESEL  = 4'd12
    } phase_t;

    // event codes
    localparam logic [1:0] OP_START     = 2'd0;
    localparam logic [1:0] OP_CMD_DONE  = 2'd1;
    localparam logic [1:0] OP_READ      = 2'd2;
    localparam logic [1:0] OP_DATA_DONE = 2'd3;

    // sd command indexes
    localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
    localparam logic [5:0] CMD_ALL_SEND_CID = 6'd2;
    localparam logic [5:0] CMD_SEND_RCA    = 6'd3;
    localparam logic [5:0] CMD_SELECT      = 6'd7;
    localparam logic [5:0] CMD_SEND_IF     = 6'd8;
    localparam logic [5:0] CMD_STATUS      = 6'd13;
    localparam logic [5:0] CMD_READ_SINGLE = 6'd17;
    localparam logic [5:0] CMD_SD_OP_COND  = 6'd41;
    localparam logic [5:0] CMD_APP         = 6'd55;

    // response kinds
    localparam logic [1:0] RESP_NONE  = 2'd0;
    localparam logic [1:0] RESP_SHORT = 2'd1;
    localparam logic [1:0] RESP_LONG  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_OP_COND_ATTEMPTS = 2'd0;
    localparam logic [1:0] CFG_STATUS_ATTEMPTS  = 2'd1;
    localparam logic [1:0] CFG_READ_ATTEMPTS    = 2'd2;

    localparam logic [11:0] IF_COND_ARG     = 12'h1AA;
    localparam logic [31:0] OCR_ARG_HCS     = 32'h4030_0000;
    localparam logic [31:0] OCR_ARG_SDSC    = 32'h0030_0000;
    localparam logic [3:0]  STATE_TRAN      = 4'd4;

    typedef struct packed {
        logic [11:0] op_cond_attempts;
        logic [2:0]  status_check_attempts;
        logic [2:0]  read_attempts;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic        version_two;
        logic        capacity_flag;
        logic [15:0] relative_addr;
        logic [11:0] poll_count;
        logic [2:0]  check_count;
        logic [2:0]  read_count;
        logic        in_read;
        logic [31:0] saved_block;
    } seq_state_t;

    typedef struct packed {
        logic [15:0] card_address;
        logic        high_capacity;
        logic        fail_status;
        logic        finished;
        logic        read_flag;
        logic [1:0]  resp_kind;
        logic [31:0] cmd_arg;
        logic [5:0]  cmd_index;
        logic        issue;
    } seq_result_t;

endpackage

>>> rtl/core/sd_card_init_read_sequencer.sv
// SD card initialization and single-block read sequencer. Each input beat is an event
// (start, command done, read request, data done); the block answers with at most one
// result beat naming the next command or reporting completion. One event is taken every
// clock unless result backpressure stalls it: an accepted beat is held in the input
// register, then the step logic updates the sequencer state and loads the result register.
// Backpressure on the result side stalls the input register only when that event actually
// produces a result. Attempt limits are set through the configuration port.
// depends on sdcis_pkg and sdcis_step
`timescale 1ns / 1ps

module sd_card_init_read_sequencer import sdcis_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // success, response[31:0], block_address[31:0], zero pad
    input  logic [1:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    // issue, cmd_index, cmd_arg, resp_kind, read_flag, finished, fail_status,
    // high_capacity, card_address, zero pad
    output logic [63:0] m_tdata
);

    cfg_t        cfg_reg;
    seq_state_t  state_reg;
    seq_state_t  state_next;
    logic        in_valid_reg;
    logic [1:0]  op_reg;
    logic        success_reg;
    logic [31:0] response_reg;
    logic [31:0] block_reg;
    logic        out_valid_reg;
    seq_result_t out_reg;
    seq_result_t step_res;
    logic        step_has;
    logic        step_fire;

    sdcis_step u_step (
        .st            (state_reg),
        .cfg           (cfg_reg),
        .op            (op_reg),
        .success       (success_reg),
        .response      (response_reg),
        .block_address (block_reg),
        .nxt           (state_next),
        .has_result    (step_has),
        .res           (step_res)
    );

    // event proceeds unless it has a result and the output slot stays full
    assign step_fire = in_valid_reg && (!step_has || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step_fire;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {3'd0, out_reg.card_address, out_reg.high_capacity,
                        out_reg.fail_status, out_reg.finished, out_reg.read_flag,
                        out_reg.resp_kind, out_reg.cmd_arg, out_reg.cmd_index, out_reg.issue};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.op_cond_attempts      <= 12'd2000;
            cfg_reg.status_check_attempts <= 3'd3;
            cfg_reg.read_attempts         <= 3'd3;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_OP_COND_ATTEMPTS: cfg_reg.op_cond_attempts      <= cfg_data;
                CFG_STATUS_ATTEMPTS:  cfg_reg.status_check_attempts <= cfg_data[2:0];
                CFG_READ_ATTEMPTS:    cfg_reg.read_attempts         <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            op_reg       <= s_tuser;
            success_reg  <= s_tdata[0];
            response_reg <= s_tdata[32:1];
            block_reg    <= s_tdata[64:33];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PH_IDLE, saved_block: 32'd0, relative_addr: 16'd0,
                           poll_count: 12'd0, default: '0};
        end else if (step_fire) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_fire && step_has) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (step_fire && step_has) begin
            out_reg <= step_res;
        end
    end

endmodule

>>> rtl/core/sdcis_step.sv
// next-state and result logic for one event of the sd card sequencer
// depends on sdcis_pkg
`timescale 1ns / 1ps

module sdcis_step import sdcis_pkg::*; (
    input  seq_state_t  st,
    input  cfg_t        cfg,
    input  logic [1:0]  op,
    input  logic        success,
    input  logic [31:0] response,
    input  logic [31:0] block_address,
    output seq_state_t  nxt,
    output logic        has_result,
    output seq_result_t res
);

    logic        do_send;
    logic        do_fin;
    logic        fail;
    logic        use_rca;
    phase_t      send_phase;
    logic [5:0]  idx;
    logic [31:0] arg;
    logic [1:0]  kind;
    logic        rd;
    logic [11:0] poll_inc;
    logic [2:0]  check_inc;
    logic [2:0]  read_inc;
    logic        tran_ok;

    assign poll_inc  = st.poll_count + 12'd1;
    assign check_inc = st.check_count + 3'd1;
    assign read_inc  = st.read_count + 3'd1;
    // card in transfer state with ready-for-data set
    assign tran_ok   = success && (response[12:9] == STATE_TRAN) && response[8];

    always_comb begin
        nxt        = st;
        do_send    = 1'b0;
        do_fin     = 1'b0;
        fail       = 1'b0;
        use_rca    = 1'b0;
        send_phase = PH_IDLE;
        idx        = CMD_GO_IDLE;
        arg        = 32'd0;
        kind       = RESP_SHORT;
        rd         = 1'b0;

        case (op)
            OP_START: begin
                nxt.in_read     = 1'b0;
                nxt.version_two = 1'b0;
                nxt.poll_count  = 12'd0;
                nxt.check_count = 3'd0;
                do_send    = 1'b1;
                send_phase = PH_CMD0;
                idx        = CMD_GO_IDLE;
                kind       = RESP_NONE;
            end
            OP_CMD_DONE: begin
                unique case (st.phase)
                    PH_CMD0: begin
                        if (!success) begin
                            do_fin = 1'b1;
                            fail   = 1'b1;
                        end else begin
                            do_send    = 1'b1;
                            send_phase = PH_CMD8;
                            idx        = CMD_SEND_IF;
                            arg        = {20'd0, IF_COND_ARG};
                        end
                    end
                    PH_CMD8: begin
                        nxt.version_two = success && (response[11:0] == IF_COND_ARG);
                        nxt.poll_count  = 12'd0;
                        do_send    = 1'b1;
                        send_phase = PH_CMD55;
                        idx        = CMD_APP;
                    end
                    PH_CMD55: begin
                        if (!success) begin
                            do_fin = 1'b1;
                            fail   = 1'b1;
                        end else begin
                            do_send    = 1'b1;
                            send_phase = PH_ACMD41;
                            idx        = CMD_SD_OP_COND;
                            arg        = st.version_two ? OCR_ARG_HCS : OCR_ARG_SDSC;
                        end
                    end
                    PH_ACMD41: begin
                        if (!success) begin
                            do_fin = 1'b1;
                            fail   = 1'b1;
                        end else if (response[31]) begin
                            nxt.capacity_flag = response[30];
                            do_send    = 1'b1;
                            send_phase = PH_CMD2;
                            idx        = CMD_ALL_SEND_CID;
                            kind       = RESP_LONG;
                        end else begin
                            nxt.poll_count = poll_inc;
                            if (poll_inc >= cfg.op_cond_attempts) begin
                                do_fin = 1'b1;
                                fail   = 1'b1;
                            end else begin
                                do_send    = 1'b1;
                                send_phase = PH_CMD55;
                                idx        = CMD_APP;
                            end
                        end
                    end
                    PH_CMD2: begin
                        if (!success) begin
                            do_fin = 1'b1;
                            fail   = 1'b1;
                        end else begin
                            do_send    = 1'b1;
                            send_phase = PH_CMD3;
                            idx        = CMD_SEND_RCA;
                        end
                    end
                    PH_CMD3: begin
                        if (!success) begin
                            do_fin = 1'b1;
                            fail   = 1'b1;
                        end else begin
                            nxt.relative_addr = response[31:16];
                            if (response[31:16] == 16'd0) begin
                                do_fin = 1'b1;
                                fail   = 1'b1;
                            end else begin
                                do_send    = 1'b1;
                                send_phase = PH_CMD7;
                                idx        = CMD_SELECT;
                                use_rca    = 1'b1;
                            end
                        end
                    end
                    PH_CMD7: begin
                        if (!success) begin
                            do_fin = 1'b1;
                            fail   = 1'b1;
                        end else begin
                            nxt.check_count = 3'd0;
                            do_send    = 1'b1;
                            send_phase = PH_CHK13;
                            idx        = CMD_STATUS;
                            use_rca    = 1'b1;
                        end
                    end
                    PH_CHK13: begin
                        if (tran_ok && !st.in_read) begin
                            do_fin = 1'b1;
                        end else if (tran_ok) begin
                            do_send    = 1'b1;
                            send_phase = PH_CMD17;
                            idx        = CMD_READ_SINGLE;
                            rd         = 1'b1;
                            // standard capacity cards take a byte address
                            arg        = st.capacity_flag ? st.saved_block
                                                          : {st.saved_block[22:0], 9'd0};
                        end else begin
                            do_send    = 1'b1;
                            send_phase = PH_CHK7;
                            idx        = CMD_SELECT;
                            use_rca    = 1'b1;
                        end
                    end
                    PH_CHK7: begin
                        nxt.check_count = check_inc;
                        do_send = 1'b1;
                        idx     = CMD_SELECT;
                        use_rca = 1'b1;
                        if (check_inc >= cfg.status_check_attempts) begin
                            if (st.in_read) begin
                                send_phase = PH_RESEL;
                            end else begin
                                do_send = 1'b0;
                                do_fin  = 1'b1;
                                fail    = 1'b1;
                            end
                        end else begin
                            send_phase = PH_CHK13;
                            idx        = CMD_STATUS;
                        end
                    end
                    PH_CMD17: begin
                        if (!success) begin
                            do_send    = 1'b1;
                            send_phase = PH_RESEL;
                            idx        = CMD_SELECT;
                            use_rca    = 1'b1;
                        end else begin
                            nxt.phase = PH_DATA;
                        end
                    end
                    PH_RESEL: begin
                        nxt.read_count = read_inc;
                        if (read_inc >= cfg.read_attempts) begin
                            do_fin = 1'b1;
                            fail   = 1'b1;
                        end else begin
                            nxt.check_count = 3'd0;
                            do_send    = 1'b1;
                            send_phase = PH_CHK13;
                            idx        = CMD_STATUS;
                            use_rca    = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            OP_READ: begin
                if (st.phase == PH_IDLE) begin
                    nxt.saved_block = block_address;
                    nxt.in_read     = 1'b1;
                    nxt.read_count  = 3'd0;
                    if (st.relative_addr == 16'd0) begin
                        do_fin = 1'b1;
                        fail   = 1'b1;
                    end else begin
                        nxt.check_count = 3'd0;
                        do_send    = 1'b1;
                        send_phase = PH_CHK13;
                        idx        = CMD_STATUS;
                        use_rca    = 1'b1;
                    end
                end
            end
            default: begin
                if (st.phase == PH_DATA) begin
                    if (success) begin
                        do_fin = 1'b1;
                    end else begin
                        do_send    = 1'b1;
                        send_phase = PH_RESEL;
                        idx        = CMD_SELECT;
                        use_rca    = 1'b1;
                    end
                end
            end
        endcase

        if (do_send) begin
            nxt.phase = send_phase;
        end
        if (do_fin) begin
            nxt.phase   = PH_IDLE;
            nxt.in_read = 1'b0;
        end
        if (use_rca) begin
            arg = {nxt.relative_addr, 16'd0};
        end

        has_result        = do_send || do_fin;
        res.issue         = do_send;
        res.cmd_index     = do_send ? idx : 6'd0;
        res.cmd_arg       = do_send ? arg : 32'd0;
        res.resp_kind     = do_send ? kind : RESP_NONE;
        res.read_flag     = do_send && rd;
        res.finished      = do_fin;
        res.fail_status   = do_fin && fail;
        res.high_capacity = nxt.capacity_flag;
        res.card_address  = nxt.relative_addr;
    end

endmodule

>>> tb/sv/tb_sd_card_init_read_sequencer.sv
// self-checking testbench for the sd card init/read sequencer: an event predictor in a
// scoreboard class, stream drivers with random gaps and a result monitor
// depends on sdcis_pkg and sd_card_init_read_sequencer
`timescale 1ns / 1ps

module tb_sd_card_init_read_sequencer import sdcis_pkg::*; ();

    localparam int         CYCLE_LIMIT    = 500000;
    localparam int         QUIET_CYCLES   = 8;
    localparam int         END_CYCLES     = 10;
    localparam int         RX_HOLD_CYCLES = 400;
    localparam int         SEG_ITEMS      = 316;
    localparam logic [1:0] CFG_UNUSED     = 2'd3;

    // predicts the command or completion beat for every accepted event
    class sd_seq_scoreboard;
        cfg_t        regs;
        seq_state_t  st;
        seq_result_t expected_q[$];
        int          errors;

        function new();
            regs = '{op_cond_attempts: 12'd2000, status_check_attempts: 3'd3,
                     read_attempts: 3'd3};
            st = '0;
            st.phase = PH_IDLE;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [11:0] val);
            case (idx)
                CFG_OP_COND_ATTEMPTS: regs.op_cond_attempts = val;
                CFG_STATUS_ATTEMPTS:  regs.status_check_attempts = val[2:0];
                CFG_READ_ATTEMPTS:    regs.read_attempts = val[2:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_result(logic iss, logic [5:0] idx, logic [31:0] arg,
                                  logic [1:0] kind, logic rd, logic fin, logic fail);
            seq_result_t r;
            r.issue         = iss;
            r.cmd_index     = idx;
            r.cmd_arg       = arg;
            r.resp_kind     = kind;
            r.read_flag     = rd;
            r.finished      = fin;
            r.fail_status   = fail;
            r.high_capacity = st.capacity_flag;
            r.card_address  = st.relative_addr;
            expected_q.push_back(r);
        endfunction

        function void issue_cmd(phase_t next, logic [5:0] idx, logic [31:0] arg,
                                logic [1:0] kind, logic rd = 1'b0);
            st.phase = next;
            push_result(1'b1, idx, arg, kind, rd, 1'b0, 1'b0);
        endfunction

        function void end_op(logic fail);
            st.phase   = PH_IDLE;
            st.in_read = 1'b0;
            push_result(1'b0, '0, '0, RESP_NONE, 1'b0, 1'b1, fail);
        endfunction

        function logic [31:0] rca_arg();
            return {st.relative_addr, 16'h0000};
        endfunction

        function void start_check();
            st.check_count = '0;
            issue_cmd(PH_CHK13, CMD_STATUS, rca_arg(), RESP_SHORT);
        endfunction

        function void reselect();
            issue_cmd(PH_RESEL, CMD_SELECT, rca_arg(), RESP_SHORT);
        endfunction

        function void command_done(logic ok, logic [31:0] resp);
            case (st.phase)
                PH_CMD0: begin
                    if (!ok) end_op(1'b1);
                    else issue_cmd(PH_CMD8, CMD_SEND_IF, 32'(IF_COND_ARG), RESP_SHORT);
                end
                PH_CMD8: begin
                    // a failed CMD8 just marks a version one card
                    st.version_two = ok && (resp[11:0] == IF_COND_ARG);
                    st.poll_count  = '0;
                    issue_cmd(PH_CMD55, CMD_APP, '0, RESP_SHORT);
                end
                PH_CMD55: begin
                    if (!ok) end_op(1'b1);
                    else issue_cmd(PH_ACMD41, CMD_SD_OP_COND,
                                   st.version_two ? OCR_ARG_HCS : OCR_ARG_SDSC, RESP_SHORT);
                end
                PH_ACMD41: begin
                    if (!ok) begin
                        end_op(1'b1);
                    end else if (resp[31]) begin
                        st.capacity_flag = resp[30];
                        issue_cmd(PH_CMD2, CMD_ALL_SEND_CID, '0, RESP_LONG);
                    end else begin
                        st.poll_count = st.poll_count + 12'd1;
                        if (st.poll_count >= regs.op_cond_attempts) end_op(1'b1);
                        else issue_cmd(PH_CMD55, CMD_APP, '0, RESP_SHORT);
                    end
                end
                PH_CMD2: begin
                    if (!ok) end_op(1'b1);
                    else issue_cmd(PH_CMD3, CMD_SEND_RCA, '0, RESP_SHORT);
                end
                PH_CMD3: begin
                    if (!ok) begin
                        end_op(1'b1);
                    end else begin
                        st.relative_addr = resp[31:16];
                        if (st.relative_addr == '0) end_op(1'b1);
                        else issue_cmd(PH_CMD7, CMD_SELECT, rca_arg(), RESP_SHORT);
                    end
                end
                PH_CMD7: begin
                    if (!ok) end_op(1'b1);
                    else start_check();
                end
                PH_CHK13: begin
                    if (ok && resp[12:9] == STATE_TRAN && resp[8]) begin
                        if (!st.in_read) end_op(1'b0);
                        else issue_cmd(PH_CMD17, CMD_READ_SINGLE,
                                       st.capacity_flag ? st.saved_block
                                                        : {st.saved_block[22:0], 9'd0},
                                       RESP_SHORT, 1'b1);
                    end else begin
                        issue_cmd(PH_CHK7, CMD_SELECT, rca_arg(), RESP_SHORT);
                    end
                end
                PH_CHK7: begin
                    // reselect outcome does not matter, only the round count
                    st.check_count = st.check_count + 3'd1;
                    if (st.check_count < regs.status_check_attempts)
                        issue_cmd(PH_CHK13, CMD_STATUS, rca_arg(), RESP_SHORT);
                    else if (st.in_read) reselect();
                    else end_op(1'b1);
                end
                PH_CMD17: begin
                    if (!ok) reselect();
                    else st.phase = PH_DATA;
                end
                PH_RESEL: begin
                    st.read_count = st.read_count + 3'd1;
                    if (st.read_count >= regs.read_attempts) end_op(1'b1);
                    else start_check();
                end
                default: ;
            endcase
        endfunction

        // returns 1 when the event was not simply ignored
        function bit note_event(logic [1:0] op, logic ok, logic [31:0] resp,
                                logic [31:0] blk);
            int     depth_was;
            phase_t phase_was;
            depth_was = pending();
            phase_was = st.phase;
            case (op)
                OP_START: begin
                    st.in_read     = 1'b0;
                    st.version_two = 1'b0;
                    st.poll_count  = '0;
                    st.check_count = '0;
                    issue_cmd(PH_CMD0, CMD_GO_IDLE, '0, RESP_NONE);
                end
                OP_CMD_DONE: command_done(ok, resp);
                OP_READ: begin
                    if (st.phase == PH_IDLE) begin
                        st.saved_block = blk;
                        st.in_read     = 1'b1;
                        st.read_count  = '0;
                        if (st.relative_addr == '0) end_op(1'b1);
                        else start_check();
                    end
                end
                default: begin
                    if (st.phase == PH_DATA) begin
                        if (ok) end_op(1'b0);
                        else reselect();
                    end
                end
            endcase
            return (op == OP_START) || (pending() != depth_was) || (st.phase != phase_was);
        endfunction

        function void cmp(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [63:0] data);
            seq_result_t got;
            seq_result_t want;
            got = data[$bits(seq_result_t)-1:0];
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected, expected none, actual %h",
                         $time, data);
                return;
            end
            want = expected_q.pop_front();
            cmp("issue", 32'(want.issue), 32'(got.issue));
            cmp("cmd_index", 32'(want.cmd_index), 32'(got.cmd_index));
            cmp("cmd_arg", want.cmd_arg, got.cmd_arg);
            cmp("resp_kind", 32'(want.resp_kind), 32'(got.resp_kind));
            cmp("read_flag", 32'(want.read_flag), 32'(got.read_flag));
            cmp("finished", 32'(want.finished), 32'(got.finished));
            cmp("fail_status", 32'(want.fail_status), 32'(got.fail_status));
            cmp("high_capacity", 32'(want.high_capacity), 32'(got.high_capacity));
            cmp("card_address", 32'(want.card_address), 32'(got.card_address));
            cmp("pad", '0, 32'(data >> $bits(seq_result_t)));
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [11:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata   = '0;  // success, response, block_address, zero pad
    logic [1:0]  s_tuser   = '0;  // op
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;         // seq_result_t from issue up, zero pad

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_token  = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int cycle_count = 0;

    sd_seq_scoreboard sb = new();

    sd_card_init_read_sequencer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_sd_card_init_read_sequencer: done, errors");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= RX_HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    task automatic push_event(input logic [1:0] op, input logic ok, input logic [31:0] resp,
                              input logic [31:0] blk, output bit handled);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, blk, resp, ok};
        do @(posedge aclk); while (!s_tready);
        handled = sb.note_event(op, ok, resp, blk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        // an ignored or data-wait event may still be in flight
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [11:0] op_lim, input logic [11:0] chk_lim,
                                  input logic [11:0] rd_lim, input bit touch_unused);
        logic [1:0]  idx_list [4];
        logic [11:0] val_list [4];
        int          n;
        idx_list = '{CFG_OP_COND_ATTEMPTS, CFG_STATUS_ATTEMPTS, CFG_READ_ATTEMPTS, CFG_UNUSED};
        val_list = '{op_lim, chk_lim, rd_lim, 12'($urandom)};
        n = touch_unused ? 4 : 3;
        drain_results();
        for (int i = 0; i < n; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data  <= val_list[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.set_reg(idx_list[i], val_list[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // mostly answers that move the sequence on, with some failures and noise
    task automatic pick_event(output logic [1:0] op, output logic ok,
                              output logic [31:0] resp, output logic [31:0] blk);
        int unsigned roll;
        int unsigned pick;
        roll = $urandom_range(99);
        pick = $urandom_range(99);
        op   = OP_CMD_DONE;
        ok   = ($urandom_range(99) < 95);
        resp = $urandom;
        blk  = $urandom;
        if (roll < 6) begin
            op = 2'($urandom_range(3));
            ok = 1'($urandom);
        end else if (roll < 8) begin
            op = OP_START;
        end else if (roll < 10) begin
            op = OP_READ;
        end else begin
            case (sb.st.phase)
                PH_IDLE: begin
                    if (sb.st.relative_addr == '0) op = (pick < 90) ? OP_START : OP_READ;
                    else op = (pick < 30) ? OP_START : OP_READ;
                end
                PH_CMD8: begin
                    ok = (pick < 85);
                    if ($urandom_range(99) < 70) resp[11:0] = IF_COND_ARG;
                end
                PH_ACMD41: resp[31] = (pick < 35);
                PH_CMD3: if (pick < 6) resp[31:16] = '0;
                PH_CHK13: begin
                    ok = (pick < 90);
                    if ($urandom_range(99) < 70) resp[12:8] = {STATE_TRAN, 1'b1};
                end
                PH_CHK7, PH_RESEL: ok = (pick < 50);
                PH_CMD17: ok = (pick < 90);
                PH_DATA: begin
                    op = OP_DATA_DONE;
                    ok = (pick < 85);
                end
                default: ;
            endcase
        end
    endtask

    task automatic run_random(input int n, input bit with_hold, input bit with_pause);
        logic [1:0]  op;
        logic        ok;
        logic [31:0] resp;
        logic [31:0] blk;
        bit          handled;
        bit          hold_sent;
        bit          pause_sent;
        int          done;
        done       = 0;
        hold_sent  = 1'b0;
        pause_sent = 1'b0;
        while (done < n) begin
            if (with_hold && !hold_sent && done >= n / 4) begin
                hold_token <= hold_token + 1;
                hold_sent = 1'b1;
            end
            if (with_pause && !pause_sent && done >= n / 2) begin
                drain_results();
                pause_sent = 1'b1;
            end
            pick_event(op, ok, resp, blk);
            push_event(op, ok, resp, blk, handled);
            if (handled) done++;
        end
    endtask

    initial begin
        bit handled;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed pass at reset settings
        push_event(OP_READ, 1'b1, '0, 32'h0000_1234, handled);      // no card address yet
        push_event(OP_CMD_DONE, 1'b1, '1, '0, handled);             // ignored while idle
        push_event(OP_DATA_DONE, 1'b1, '0, '0, handled);            // ignored outside data wait
        push_event(OP_START, 1'b0, '0, '0, handled);
        push_event(OP_CMD_DONE, 1'b0, '0, '0, handled);             // CMD0 fails
        push_event(OP_START, 1'b0, '0, '0, handled);
        push_event(OP_CMD_DONE, 1'b1, '0, '0, handled);
        push_event(OP_CMD_DONE, 1'b0, 32'h0000_01AA, '0, handled);  // CMD8 failure is benign
        push_event(OP_CMD_DONE, 1'b1, '0, '0, handled);
        push_event(OP_CMD_DONE, 1'b1, '0, '0, handled);             // card busy, poll again
        push_event(OP_START, 1'b1, '1, '1, handled);                // restart while busy
        push_event(OP_CMD_DONE, 1'b1, '0, '0, handled);
        push_event(OP_CMD_DONE, 1'b1, 32'hFFFF_F1AA, '0, handled);
        push_event(OP_CMD_DONE, 1'b1, '0, '0, handled);
        push_event(OP_CMD_DONE, 1'b1, 32'hC0FF_8000, '0, handled);  // ready, high capacity
        push_event(OP_READ, 1'b1, '0, '1, handled);                 // ignored while busy
        push_event(OP_CMD_DONE, 1'b1, '0, '0, handled);
        push_event(OP_CMD_DONE, 1'b1, 32'hFFFF_0000, '0, handled);
        push_event(OP_CMD_DONE, 1'b1, '0, '0, handled);
        push_event(OP_CMD_DONE, 1'b0, 32'h0000_0900, '0, handled);  // status check fails
        push_event(OP_CMD_DONE, 1'b0, '0, '0, handled);             // failed reselect ignored
        push_event(OP_CMD_DONE, 1'b1, 32'h0000_0900, '0, handled);
        push_event(OP_READ, 1'b0, '0, '1, handled);
        push_event(OP_CMD_DONE, 1'b1, 32'hFFFF_E9FF, '0, handled);
        push_event(OP_CMD_DONE, 1'b1, '0, '0, handled);             // CMD17 taken, no beat
        push_event(OP_CMD_DONE, 1'b1, '0, '0, handled);             // ignored in data wait
        push_event(OP_DATA_DONE, 1'b0, '0, '0, handled);
        push_event(OP_CMD_DONE, 1'b0, '0, '0, handled);

        for (int m = 0; m < 3; m++) begin
            tx_idle_pct  = (m == 0) ? 37 : (m == 1) ? 73 : 0;
            rx_idle_pct <= (m == 0) ? 73 : (m == 1) ? 37 : 0;
            for (int k = 0; k < 2; k++) begin
                case (2 * m + k)
                    0: apply_settings(12'd4095, 12'd7, 12'd7, 1'b1);
                    1: apply_settings(12'd1, 12'd1, 12'd1, 1'b0);
                    2: apply_settings(12'd0, 12'd0, 12'd0, 1'b0);
                    3: apply_settings(12'($urandom), 12'($urandom), 12'($urandom), 1'b1);
                    4: apply_settings(12'd2000, 12'd3, 12'd3, 1'b0);
                    default: apply_settings(12'($urandom_range(64, 1)),
                                            12'($urandom_range(7, 1)),
                                            12'($urandom_range(7, 1)), 1'b0);
                endcase
                run_random(SEG_ITEMS, (m == 2) && (k == 0), (m == 0) && (k == 1));
            end
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (END_CYCLES) @(posedge aclk);
        if (sb.pending() != 0) sb.errors += sb.pending();
        if (sb.errors == 0) begin
            $display("tb_sd_card_init_read_sequencer: done, clean");
        end else begin
            $display("tb_sd_card_init_read_sequencer: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/sdcis_pkg.sv
rtl/core/sdcis_step.sv
rtl/core/sd_card_init_read_sequencer.sv
tb/sv/tb_sd_card_init_read_sequencer.sv
